@@ rtl/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU response framer package
// Word types, frame constants and the byte-wide CRC-16 update shared by the
// framer.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  // Input word: a response header or one read data byte.
  typedef struct packed {
    logic        op;
    logic [6:0]  func_code;
    logic [7:0]  exception_code;
    logic [15:0] start_address;
    logic [15:0] count_or_value;
    logic [7:0]  data_byte;
  } req_word_t;

  // Output word: one byte of the frame.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } rsp_word_t;

  // Input word kinds.
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // Frame constants.
  localparam logic [7:0]  EXC_FLAG    = 8'h80;
  localparam logic [7:0]  COUNT_MAX   = 8'd250;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  SLAVE_RESET = 8'd1;

  // Function codes that open a read response.
  localparam logic [6:0] FC_READ_FIRST = 7'd1;
  localparam logic [6:0] FC_READ_COILS = 7'd2;
  localparam logic [6:0] FC_READ_LAST  = 7'd4;

  // Frame buffer: the longest header-built run of covered bytes (write echo).
  localparam int unsigned BUF_DEPTH = 6;
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);

  // Number of CRC bytes appended to a frame.
  localparam logic [1:0] CRC_BYTES = 2'd2;

  // One byte of the reflected Modbus CRC-16, eight shift steps unrolled.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/modbus_rtu_response_framer.sv @@
// The first byte of an accepted word is loaded into the frame buffer and then registered
// into rsp_word. Throughput: one frame byte per cycle while rsp is not stalled; the next
// word is taken in the cycle its last byte moves on. A dropped data word gives no bytes.
// Reset (rst, synchronous, active high) empties the serialiser and output register,
// sets the CRC to 0xFFFF, clears the read-frame tracking and sets slave_address to 1.
// ----------------------------------------------------------------------------
// Modbus RTU response framer
// Turns header and data words into a Modbus RTU response byte stream with the
// CRC-16 appended, computing the CRC one byte per cycle as bytes leave, unless rsp stalls.
// ----------------------------------------------------------------------------
module modbus_rtu_response_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  mbrtu_pkg::req_word_t req_word,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output mbrtu_pkg::rsp_word_t rsp_word
);
  import mbrtu_pkg::*;

  // Configuration and read-frame tracking.
  logic [7:0] slave_address;
  logic       in_read_frame;
  logic       in_read_frame_next;
  logic [7:0] data_bytes_left;
  logic [7:0] data_bytes_left_next;

  // Byte serialiser.
  logic [7:0]       frame_buf [BUF_DEPTH];
  logic [7:0]       ld_buf    [BUF_DEPTH];
  logic [CNT_W-1:0] data_cnt;
  logic [CNT_W-1:0] data_cnt_next;
  logic [CNT_W-1:0] ld_data_cnt;
  logic [1:0]       crc_left;
  logic [1:0]       crc_left_next;
  logic [1:0]       ld_crc_left;
  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic             ld_header;

  // Handshake and output register.
  logic      accept;
  logic      busy;
  logic      out_free;
  logic      emit;
  logic      last_emit;
  logic      rsp_valid_next;
  rsp_word_t emit_word;

  // Byte count of a read response.
  logic [13:0] coil_cnt;
  logic [16:0] reg_cnt;
  logic [7:0]  byte_cnt;
  logic        is_read;

  assign busy      = (data_cnt != '0) || (crc_left != '0);
  assign out_free  = !rsp_valid || rsp_ready;
  assign emit      = busy && out_free;
  assign last_emit = ((data_cnt == CNT_W'(1)) && (crc_left == '0)) ||
                     ((data_cnt == '0) && (crc_left == 2'd1));
  assign req_ready = !busy || (out_free && last_emit);
  assign accept    = req_valid && req_ready;

  // Byte count: ceil(n/8) for coils and inputs, 2n for registers, capped.
  always_comb begin
    coil_cnt = {1'b0, req_word.count_or_value[15:3]} +
               {13'd0, |req_word.count_or_value[2:0]};
    reg_cnt  = {req_word.count_or_value, 1'b0};
    is_read  = (req_word.func_code >= FC_READ_FIRST) &&
               (req_word.func_code <= FC_READ_LAST);
    if (req_word.func_code <= FC_READ_COILS) begin
      byte_cnt = (coil_cnt > 14'(COUNT_MAX)) ? COUNT_MAX : coil_cnt[7:0];
    end else begin
      byte_cnt = (reg_cnt > 17'(COUNT_MAX)) ? COUNT_MAX : reg_cnt[7:0];
    end
  end

  // Decode of the input word into a run of covered bytes and a CRC tail.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      ld_buf[i] = 8'h00;
    end
    ld_data_cnt          = '0;
    ld_crc_left          = '0;
    ld_header            = 1'b0;
    in_read_frame_next   = in_read_frame;
    data_bytes_left_next = data_bytes_left;
    if (req_word.op == OP_DATA) begin
      if (in_read_frame) begin
        ld_buf[0]            = req_word.data_byte;
        ld_data_cnt          = CNT_W'(1);
        data_bytes_left_next = data_bytes_left - 8'd1;
        if (data_bytes_left == 8'd1) begin
          ld_crc_left        = CRC_BYTES;
          in_read_frame_next = 1'b0;
        end
      end
    end else begin
      ld_header            = 1'b1;
      in_read_frame_next   = 1'b0;
      data_bytes_left_next = 8'd0;
      ld_buf[0]            = slave_address;
      if (req_word.exception_code != 8'h00) begin
        ld_buf[1]   = EXC_FLAG | {1'b0, req_word.func_code};
        ld_buf[2]   = req_word.exception_code;
        ld_data_cnt = CNT_W'(3);
        ld_crc_left = CRC_BYTES;
      end else if (is_read) begin
        ld_buf[1]   = {1'b0, req_word.func_code};
        ld_buf[2]   = byte_cnt;
        ld_data_cnt = CNT_W'(3);
        if (byte_cnt == 8'd0) begin
          ld_crc_left = CRC_BYTES;
        end else begin
          in_read_frame_next   = 1'b1;
          data_bytes_left_next = byte_cnt;
        end
      end else begin
        ld_buf[1]   = {1'b0, req_word.func_code};
        ld_buf[2]   = req_word.start_address[15:8];
        ld_buf[3]   = req_word.start_address[7:0];
        ld_buf[4]   = req_word.count_or_value[15:8];
        ld_buf[5]   = req_word.count_or_value[7:0];
        ld_data_cnt = CNT_W'(BUF_DEPTH);
        ld_crc_left = CRC_BYTES;
      end
    end
  end

  // Serialiser step: covered bytes first, then CRC low and CRC high.
  always_comb begin
    emit_word     = '{out_byte: frame_buf[0], frame_last: 1'b0};
    crc_next      = crc;
    data_cnt_next = data_cnt;
    crc_left_next = crc_left;
    if (emit) begin
      if (data_cnt != '0) begin
        crc_next      = crc_byte(crc, frame_buf[0]);
        data_cnt_next = data_cnt - CNT_W'(1);
      end else if (crc_left == CRC_BYTES) begin
        emit_word.out_byte = crc[7:0];
        crc_left_next      = 2'd1;
      end else begin
        emit_word.out_byte   = crc[15:8];
        emit_word.frame_last = 1'b1;
        crc_next             = CRC_INIT;
        crc_left_next        = '0;
      end
    end
    if (accept) begin
      data_cnt_next = ld_data_cnt;
      crc_left_next = ld_crc_left;
      if (ld_header) begin
        crc_next = CRC_INIT;
      end
    end
  end

  // Output register valid: set on a byte moving in, cleared when taken.
  always_comb begin
    if (emit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address   <= SLAVE_RESET;
      in_read_frame   <= 1'b0;
      data_bytes_left <= 8'd0;
      data_cnt        <= '0;
      crc_left        <= '0;
      crc             <= CRC_INIT;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        slave_address <= cfg_wdata;
      end
      if (accept) begin
        in_read_frame   <= in_read_frame_next;
        data_bytes_left <= data_bytes_left_next;
      end
      data_cnt  <= data_cnt_next;
      crc_left  <= crc_left_next;
      crc       <= crc_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers: frame buffer loads on accept, shifts one byte per covered byte sent.
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_buf <= ld_buf;
    end else if (emit && (data_cnt != '0)) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) begin
        frame_buf[i] <= frame_buf[i+1];
      end
      frame_buf[BUF_DEPTH-1] <= 8'h00;
    end
    if (emit) begin
      rsp_word <= emit_word;
    end
  end

  // The serialiser never holds off a word while it has nothing left to send.
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> req_ready)
    else $error("framer not ready while serialiser idle");

  // An open read frame always expects at least one more data byte.
  a_read_frame_count: assert property (@(posedge clk) disable iff (rst)
    in_read_frame |-> (data_bytes_left != 8'd0))
    else $error("open read frame with no data bytes left");

  // Sending the closing CRC byte restarts the CRC for the next frame.
  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_word.frame_last) |=> (crc == CRC_INIT))
    else $error("CRC not restarted after frame end");

  // CRC bytes only follow once every covered byte has been sent.
  a_crc_after_data: assert property (@(posedge clk) disable iff (rst)
    (crc_left == 2'd1) |-> (data_cnt == '0))
    else $error("CRC tail mixed with pending data bytes");

endmodule
